// File: hdl/lfps_pkg.sv
// Shared types, widths and reset values for the line-follow PID steering core.
package lfps_pkg;

	localparam int POSITION_BITS_DEF = 10;

	localparam int CENTER_W   = 10;
	localparam int GAIN_W     = 32;
	localparam int DUTY_W     = 10;
	localparam int CORR_W     = 11;
	localparam int ESUM_W     = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam int FRAC_BITS  = 16;
	localparam int LIMIT_EXP  = 40;
	localparam int TOTAL_W    = 66;
	localparam int LIMIT_W    = LIMIT_EXP + 2;
	localparam int RND_W      = LIMIT_W - FRAC_BITS;

	localparam int CENTER_RST     = 250;
	localparam int GAIN_P_RST     = 655360;
	localparam int GAIN_I_RST     = 655;
	localparam int GAIN_D_RST     = 6553600;
	localparam int MAX_DUTY_RST   = 650;
	localparam int START_DUTY_RST = 150;
	localparam int RAMP_STEP_RST  = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER     = 3'd0,
		REG_GAIN_P     = 3'd1,
		REG_GAIN_I     = 3'd2,
		REG_GAIN_D     = 3'd3,
		REG_MAX_DUTY   = 3'd4,
		REG_START_DUTY = 3'd5,
		REG_RAMP_STEP  = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [CENTER_W-1:0] center;
		logic [GAIN_W-1:0]   gain_p;
		logic [GAIN_W-1:0]   gain_i;
		logic [GAIN_W-1:0]   gain_d;
		logic [DUTY_W-1:0]   max_duty;
		logic [DUTY_W-1:0]   start_duty;
		logic [DUTY_W-1:0]   ramp_step;
	} cfg_t;

	typedef struct packed {
		logic              load;
		logic [DUTY_W-1:0] value;
	} base_load_t;

endpackage

// File: hdl/lfps_cfg.sv
// Configuration register file with start duty load strobe.
module lfps_cfg import lfps_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg,
	output base_load_t            base_load
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_comb begin
		base_load.load  = cfg_valid && (cfg_reg_t'(cfg_index) == REG_START_DUTY);
		base_load.value = cfg_data[DUTY_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{
				center:     CENTER_W'(CENTER_RST),
				gain_p:     GAIN_W'(GAIN_P_RST),
				gain_i:     GAIN_W'(GAIN_I_RST),
				gain_d:     GAIN_W'(GAIN_D_RST),
				max_duty:   DUTY_W'(MAX_DUTY_RST),
				start_duty: DUTY_W'(START_DUTY_RST),
				ramp_step:  DUTY_W'(RAMP_STEP_RST)
			};
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_CENTER:     cfg_q.center     <= cfg_data[CENTER_W-1:0];
				REG_GAIN_P:     cfg_q.gain_p     <= cfg_data[GAIN_W-1:0];
				REG_GAIN_I:     cfg_q.gain_i     <= cfg_data[GAIN_W-1:0];
				REG_GAIN_D:     cfg_q.gain_d     <= cfg_data[GAIN_W-1:0];
				REG_MAX_DUTY:   cfg_q.max_duty   <= cfg_data[DUTY_W-1:0];
				REG_START_DUTY: cfg_q.start_duty <= cfg_data[DUTY_W-1:0];
				REG_RAMP_STEP:  cfg_q.ramp_step  <= cfg_data[DUTY_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// File: hdl/lfps_front.sv
// Input stage: position hold, error, saturating integral, derivative and duty ramp.
module lfps_front import lfps_pkg::*; #(
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [POSITION_BITS-1:0] line_position,
	input  logic                     position_valid,
	input  cfg_t                     cfg,
	input  base_load_t               base_load,
	output logic                     v_s1,
	input  logic                     next_ready,
	output logic signed [((POSITION_BITS > CENTER_W) ? POSITION_BITS : CENTER_W):0] err_s1,
	output logic signed [ESUM_W-1:0] esum_s1,
	output logic signed [((POSITION_BITS > CENTER_W) ? POSITION_BITS : CENTER_W)+1:0] diff_s1,
	output logic [DUTY_W-1:0]        base_s1
);

	localparam int ERR_W = ((POSITION_BITS > CENTER_W) ? POSITION_BITS : CENTER_W) + 1;

	logic [POSITION_BITS-1:0] held_q;
	logic signed [ERR_W-1:0]  last_err_q;
	logic signed [ESUM_W-1:0] esum_q;
	logic [DUTY_W-1:0]        base_q;

	logic                     acc;
	logic [POSITION_BITS-1:0] pos_use;
	logic signed [ERR_W-1:0]  err;
	logic signed [ESUM_W:0]   isum;
	logic signed [ESUM_W-1:0] esum_nxt;
	logic signed [ERR_W:0]    diff;
	logic [DUTY_W:0]          base_sum;
	logic [DUTY_W-1:0]        base_nxt;

	assign in_ready = !v_s1 || next_ready;
	assign acc      = in_valid && in_ready;

	always_comb begin
		pos_use = position_valid ? line_position : held_q;
		err     = $signed(ERR_W'(pos_use)) - $signed(ERR_W'(cfg.center));
		isum    = (ESUM_W+1)'(esum_q) + (ESUM_W+1)'(err);
		// clip to the signed 32-bit range
		if (isum[ESUM_W] != isum[ESUM_W-1]) begin
			esum_nxt = {isum[ESUM_W], {(ESUM_W-1){!isum[ESUM_W]}}};
		end else begin
			esum_nxt = isum[ESUM_W-1:0];
		end
		diff     = (ERR_W+1)'(err) - (ERR_W+1)'(last_err_q);
		base_sum = {1'b0, base_q} + {1'b0, cfg.ramp_step};
		if (base_q < cfg.max_duty) begin
			base_nxt = (base_sum > {1'b0, cfg.max_duty}) ? cfg.max_duty : base_sum[DUTY_W-1:0];
		end else begin
			base_nxt = base_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q     <= POSITION_BITS'(CENTER_RST);
			last_err_q <= '0;
			esum_q     <= '0;
			base_q     <= DUTY_W'(START_DUTY_RST);
			v_s1       <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (acc) begin
				held_q     <= pos_use;
				last_err_q <= err;
				esum_q     <= esum_nxt;
			end
			if (base_load.load) begin
				base_q <= base_load.value;
			end else if (acc) begin
				base_q <= base_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			err_s1  <= err;
			esum_s1 <= esum_nxt;
			diff_s1 <= diff;
			base_s1 <= base_q;
		end
	end

	a_hold_position: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !position_valid |=> $stable(held_q))
		else $error("held position changed on a word without a valid reading");

	a_ramp_ceiling: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !base_load.load && (base_q < cfg.max_duty) |=> base_q <= $past(cfg.max_duty))
		else $error("base duty ramped past its ceiling");

endmodule

// File: hdl/lfps_mult.sv
// Product stage: proportional, integral and derivative terms.
module lfps_mult import lfps_pkg::*; #(
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	input  logic                     v_s1,
	output logic                     ready_s1,
	input  logic signed [((POSITION_BITS > CENTER_W) ? POSITION_BITS : CENTER_W):0] err_s1,
	input  logic signed [ESUM_W-1:0] esum_s1,
	input  logic signed [((POSITION_BITS > CENTER_W) ? POSITION_BITS : CENTER_W)+1:0] diff_s1,
	input  logic [DUTY_W-1:0]        base_s1,
	output logic                     v_s2,
	input  logic                     next_ready,
	output logic signed [GAIN_W+((POSITION_BITS > CENTER_W) ? POSITION_BITS : CENTER_W)+1:0] p_s2,
	output logic signed [GAIN_W+ESUM_W:0] i_s2,
	output logic signed [GAIN_W+((POSITION_BITS > CENTER_W) ? POSITION_BITS : CENTER_W)+2:0] d_s2,
	output logic [DUTY_W-1:0]        base_s2
);

	localparam int ERR_W = ((POSITION_BITS > CENTER_W) ? POSITION_BITS : CENTER_W) + 1;

	logic signed [GAIN_W+ERR_W:0]   p_prod;
	logic signed [GAIN_W+ESUM_W:0]  i_prod;
	logic signed [GAIN_W+ERR_W+1:0] d_prod;

	assign ready_s1 = !v_s2 || next_ready;

	always_comb begin
		p_prod = $signed({1'b0, cfg.gain_p}) * err_s1;
		i_prod = $signed({1'b0, cfg.gain_i}) * esum_s1;
		d_prod = $signed({1'b0, cfg.gain_d}) * diff_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ready_s1) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && v_s1) begin
			p_s2    <= p_prod;
			i_s2    <= i_prod;
			d_s2    <= d_prod;
			base_s2 <= base_s1;
		end
	end

endmodule

// File: hdl/lfps_back.sv
// Sum, limit, round, duty clamp and output register.
module lfps_back import lfps_pkg::*; #(
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     v_s2,
	output logic                     ready_s2,
	input  logic signed [GAIN_W+((POSITION_BITS > CENTER_W) ? POSITION_BITS : CENTER_W)+1:0] p_s2,
	input  logic signed [GAIN_W+ESUM_W:0] i_s2,
	input  logic signed [GAIN_W+((POSITION_BITS > CENTER_W) ? POSITION_BITS : CENTER_W)+2:0] d_s2,
	input  logic [DUTY_W-1:0]        base_s2,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [DUTY_W-1:0]        left_duty,
	output logic [DUTY_W-1:0]        right_duty,
	output logic signed [CORR_W-1:0] correction
);

	localparam logic signed [TOTAL_W-1:0] LIM_POS =
		{{(TOTAL_W-LIMIT_EXP-1){1'b0}}, 1'b1, {LIMIT_EXP{1'b0}}};
	localparam logic signed [TOTAL_W-1:0] LIM_NEG = -LIM_POS;
	localparam logic signed [LIMIT_W-1:0] HALF =
		{{(LIMIT_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

	logic                       v_s3;
	logic                       ready_s3;
	logic signed [TOTAL_W-1:0]  total_s3;
	logic [DUTY_W-1:0]          base_s3;

	logic signed [LIMIT_W-1:0]  lim;
	logic signed [LIMIT_W-1:0]  rnd;
	logic signed [RND_W-1:0]    whole;
	logic signed [RND_W-1:0]    bpos;
	logic signed [CORR_W-1:0]   corr;
	logic signed [CORR_W-1:0]   bsig;
	logic [DUTY_W-1:0]          left_nxt;
	logic [DUTY_W-1:0]          right_nxt;

	logic [DUTY_W-1:0]          left_q;
	logic [DUTY_W-1:0]          right_q;
	logic signed [CORR_W-1:0]   corr_q;

	assign ready_s3 = !out_valid || out_ready;
	assign ready_s2 = !v_s3 || ready_s3;

	always_comb begin
		if (total_s3 > LIM_POS) begin
			lim = LIM_POS[LIMIT_W-1:0];
		end else if (total_s3 < LIM_NEG) begin
			lim = LIM_NEG[LIMIT_W-1:0];
		end else begin
			lim = total_s3[LIMIT_W-1:0];
		end
		// round to nearest, ties up
		rnd   = lim + HALF;
		whole = rnd[LIMIT_W-1:FRAC_BITS];
		bpos  = $signed(RND_W'(base_s3));
		bsig  = $signed(CORR_W'(base_s3));
		if (whole > bpos) begin
			corr = bsig;
		end else if (whole < -bpos) begin
			corr = -bsig;
		end else begin
			corr = whole[CORR_W-1:0];
		end
		if (corr < 0) begin
			left_nxt  = DUTY_W'(bsig + corr);
			right_nxt = base_s3;
		end else begin
			left_nxt  = base_s3;
			right_nxt = DUTY_W'(bsig - corr);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (ready_s2) begin
				v_s3 <= v_s2;
			end
			if (ready_s3) begin
				out_valid <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && v_s2) begin
			total_s3 <= TOTAL_W'(p_s2) + TOTAL_W'(i_s2) + TOTAL_W'(d_s2);
			base_s3  <= base_s2;
		end
		if (ready_s3 && v_s3) begin
			left_q  <= left_nxt;
			right_q <= right_nxt;
			corr_q  <= corr;
		end
	end

	assign left_duty  = left_q;
	assign right_duty = right_q;
	assign correction = corr_q;

	a_duty_split: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (CORR_W'({1'b0, left_q}) - CORR_W'({1'b0, right_q})) == corr_q)
		else $error("duty split disagrees with correction");

	a_sum_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !ready_s3 |=> v_s3 && $stable(total_s3) && $stable(base_s3))
		else $error("sum stage lost a stalled word");

endmodule

// File: hdl/line_follow_pid_steering_core.sv
// Top level of the line-follow PID steering core.
//
//   channel | direction | handshake           | payload
//   in      | in        | in_valid/in_ready   | line_position, position_valid
//   out     | out       | out_valid/out_ready | left_duty, right_duty, correction
//   cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One word per cycle in and out unless out_ready stalls; from acceptance to out_valid:
// state stage, multiplier stage, sum stage, output register.
// Position hold, integral, last error and base duty update at acceptance, so words
// follow each other in consecutive cycles; the three 32-bit multiplies set the stage depth.
// arst_n clears pipeline valids and loads the reset state and register values.
// A stalled output holds every stage; in_ready drops only when the whole pipeline is full.
module line_follow_pid_steering_core import lfps_pkg::*; #(
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [POSITION_BITS-1:0] line_position,
	input  logic                     position_valid,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [DUTY_W-1:0]        left_duty,
	output logic [DUTY_W-1:0]        right_duty,
	output logic signed [CORR_W-1:0] correction,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data
);

	localparam int ERR_W = ((POSITION_BITS > CENTER_W) ? POSITION_BITS : CENTER_W) + 1;

	cfg_t                       cfg;
	base_load_t                 base_load;

	logic                       v_s1;
	logic                       ready_s1;
	logic signed [ERR_W-1:0]    err_s1;
	logic signed [ESUM_W-1:0]   esum_s1;
	logic signed [ERR_W:0]      diff_s1;
	logic [DUTY_W-1:0]          base_s1;

	logic                       v_s2;
	logic                       ready_s2;
	logic signed [GAIN_W+ERR_W:0]   p_s2;
	logic signed [GAIN_W+ESUM_W:0]  i_s2;
	logic signed [GAIN_W+ERR_W+1:0] d_s2;
	logic [DUTY_W-1:0]          base_s2;

	lfps_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.base_load (base_load)
	);

	lfps_front #(.POSITION_BITS(POSITION_BITS)) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.line_position  (line_position),
		.position_valid (position_valid),
		.cfg            (cfg),
		.base_load      (base_load),
		.v_s1           (v_s1),
		.next_ready     (ready_s1),
		.err_s1         (err_s1),
		.esum_s1        (esum_s1),
		.diff_s1        (diff_s1),
		.base_s1        (base_s1)
	);

	lfps_mult #(.POSITION_BITS(POSITION_BITS)) u_mult (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.v_s1       (v_s1),
		.ready_s1   (ready_s1),
		.err_s1     (err_s1),
		.esum_s1    (esum_s1),
		.diff_s1    (diff_s1),
		.base_s1    (base_s1),
		.v_s2       (v_s2),
		.next_ready (ready_s2),
		.p_s2       (p_s2),
		.i_s2       (i_s2),
		.d_s2       (d_s2),
		.base_s2    (base_s2)
	);

	lfps_back #(.POSITION_BITS(POSITION_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.v_s2       (v_s2),
		.ready_s2   (ready_s2),
		.p_s2       (p_s2),
		.i_s2       (i_s2),
		.d_s2       (d_s2),
		.base_s2    (base_s2),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.left_duty  (left_duty),
		.right_duty (right_duty),
		.correction (correction)
	);

endmodule
